### src/stack_machine_executor_unit_assert.svh
// ----------------------------------------------------------------------------
// Stack machine executor assertion macros
// Concurrent assertion helpers clocked on clk with synchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SMEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SMEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SMEU_ASSERT(lbl, prop, msg)
`define SMEU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/smeu_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine executor package
// Opcodes, status codes, sequencer states and shared unit types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package smeu_pkg;

  localparam int STACK_DEPTH_DEF = 256;

  localparam logic [7:0] OP_NOP    = 8'h01;
  localparam logic [7:0] OP_HALT   = 8'h02;
  localparam logic [7:0] OP_POP    = 8'h10;
  localparam logic [7:0] OP_PUSH   = 8'h11;
  localparam logic [7:0] OP_DUP    = 8'h12;
  localparam logic [7:0] OP_SWAP   = 8'h13;
  localparam logic [7:0] OP_COUNT  = 8'h14;
  localparam logic [7:0] OP_GET    = 8'h15;
  localparam logic [7:0] OP_ADD    = 8'h21;
  localparam logic [7:0] OP_SUB    = 8'h22;
  localparam logic [7:0] OP_MUL    = 8'h23;
  localparam logic [7:0] OP_DIV    = 8'h24;
  localparam logic [7:0] OP_POW    = 8'h25;
  localparam logic [7:0] OP_IN     = 8'h30;
  localparam logic [7:0] OP_OUT    = 8'h31;
  localparam logic [7:0] OP_IN_CH  = 8'h32;
  localparam logic [7:0] OP_OUT_CH = 8'h33;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_HALT   = 3'd1;
  localparam logic [2:0] ST_BADCMD = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;
  localparam logic [2:0] ST_DIV0   = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_POP, S_POPW, S_GET, S_GETW, S_DUPW, S_ALUW, S_PUSH, S_PUSH2
  } seq_state_t;

  typedef enum logic [1:0] {ALU_MUL, ALU_DIV, ALU_POW} alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;

endpackage

### src/smeu_if.sv
// ----------------------------------------------------------------------------
// Stack machine executor channel interfaces
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface smeu_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         opcode;
  logic signed [31:0] immediate;
  logic signed [31:0] input_word;
  modport source (output valid, output opcode, output immediate, output input_word,
                  input ready);
  modport sink (input valid, input opcode, input immediate, input input_word,
                output ready);
endinterface

interface smeu_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               out_valid;
  logic signed [31:0] out_word;
  modport source (output valid, output status, output out_valid, output out_word,
                  input ready);
  modport sink (input valid, input status, input out_valid, input out_word,
                output ready);
endinterface

### src/stack_machine_executor_unit.sv
// ----------------------------------------------------------------------------
// Stack machine executor
// Executes one stack-machine instruction per item on a private stack.
// ----------------------------------------------------------------------------
// Usage: each item on in_item carries an opcode, an immediate and an input
// word; each produces exactly one result item on out_item with a status
// code, an output-valid flag and the output word (zero unless an output
// instruction delivered one). The block handles one item at a time: ready
// drops on acceptance and rises again once the result item has been taken.
// The time from acceptance to result is set by the sequencer and the
// registered stack read port: nop, halt and bad commands finish in decode,
// pops pass through the pop and pop-wait states, get and dup add a read-wait
// state, and multiply, divide and power wait on the ALU, where power runs a
// multiply and a square phase per exponent bit on the shared multiplier.
// Reset empties the stack; entries are not cleared and are only read below
// the depth. A stalled receiver holds the result item, and no new item is
// taken until it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stack_machine_executor_unit
  import smeu_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  smeu_in_if.sink   in_item,
  smeu_out_if.source out_item
);

  `include "stack_machine_executor_unit_assert.svh"

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  seq_state_t  state_r, state_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [31:0] imm_r, imm_nxt;
  logic [31:0] inw_r, inw_nxt;
  logic [31:0] t0_r, t0_nxt;
  logic [31:0] t1_r, t1_nxt;
  logic [31:0] pv_r, pv_nxt;
  logic        pop_idx_r, pop_idx_nxt;
  logic        res_valid_r, res_valid_nxt;
  logic [2:0]  res_status_r, res_status_nxt;
  logic        res_ov_r, res_ov_nxt;
  logic [31:0] res_word_r, res_word_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data, rd_data;
  logic [DW-1:0] depth_m1;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;
  logic [31:0]   alu_result;

  logic accept, empty, full, two_pops, bad_index;

  assign accept    = in_item.valid && in_item.ready;
  assign empty     = (depth_r == '0);
  assign full      = (depth_r == DW'(STACK_DEPTH));
  assign depth_m1  = depth_r - DW'(1);
  assign two_pops  = (op_r == OP_SWAP) || (op_r == OP_ADD) || (op_r == OP_SUB) ||
                     (op_r == OP_MUL) || (op_r == OP_DIV) || (op_r == OP_POW);
  assign bad_index = t0_r[31] || (t0_r >= 32'(depth_r));

  smeu_stack #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  smeu_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (rd_data),
    .b      (t0_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (op_r)
          OP_PUSH, OP_IN, OP_IN_CH, OP_COUNT: state_nxt = S_PUSH;
          OP_DUP: state_nxt = empty ? S_IDLE : S_DUPW;
          OP_POP, OP_SWAP, OP_GET, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW,
          OP_OUT, OP_OUT_CH: state_nxt = S_POP;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_POP: state_nxt = empty ? S_IDLE : S_POPW;
      S_POPW: begin
        if (!pop_idx_r && two_pops) begin
          state_nxt = S_POP;
        end else begin
          case (op_r)
            OP_GET: state_nxt = S_GET;
            OP_SWAP, OP_ADD, OP_SUB: state_nxt = S_PUSH;
            OP_MUL, OP_POW: state_nxt = S_ALUW;
            OP_DIV: state_nxt = (t0_r == 32'd0) ? S_IDLE : S_ALUW;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_GET: state_nxt = bad_index ? S_IDLE : S_GETW;
      S_GETW: state_nxt = S_PUSH;
      S_DUPW: state_nxt = S_PUSH;
      S_ALUW: begin
        if (alu_rsp.done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: state_nxt = (!full && op_r == OP_SWAP) ? S_PUSH2 : S_IDLE;
      S_PUSH2: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    depth_nxt      = depth_r;
    op_nxt         = op_r;
    imm_nxt        = imm_r;
    inw_nxt        = inw_r;
    t0_nxt         = t0_r;
    t1_nxt         = t1_r;
    pv_nxt         = pv_r;
    pop_idx_nxt    = pop_idx_r;
    res_valid_nxt  = res_valid_r && !out_item.ready;
    res_status_nxt = res_status_r;
    res_ov_nxt     = res_ov_r;
    res_word_nxt   = res_word_r;
    wr_en          = 1'b0;
    wr_addr        = depth_r[AW-1:0];
    wr_data        = pv_r;
    rd_en          = 1'b0;
    rd_addr        = depth_m1[AW-1:0];
    alu_req.start  = 1'b0;
    alu_req.op     = ALU_MUL;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_item.opcode;
          imm_nxt     = in_item.immediate;
          inw_nxt     = in_item.input_word;
          pop_idx_nxt = 1'b0;
        end
      end
      S_DEC: begin
        res_status_nxt = ST_OK;
        res_ov_nxt     = 1'b0;
        res_word_nxt   = '0;
        case (op_r)
          OP_NOP: res_valid_nxt = 1'b1;
          OP_HALT: begin
            res_status_nxt = ST_HALT;
            res_valid_nxt  = 1'b1;
          end
          OP_PUSH: pv_nxt = imm_r;
          OP_IN, OP_IN_CH: pv_nxt = inw_r;
          OP_COUNT: pv_nxt = 32'(depth_r);
          OP_DUP: begin
            if (empty) begin
              res_status_nxt = ST_EMPTY;
              res_valid_nxt  = 1'b1;
            end else begin
              rd_en = 1'b1;
            end
          end
          OP_POP, OP_SWAP, OP_GET, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW,
          OP_OUT, OP_OUT_CH: ;
          default: begin
            res_status_nxt = ST_BADCMD;
            res_valid_nxt  = 1'b1;
          end
        endcase
      end
      S_POP: begin
        if (empty) begin
          res_status_nxt = ST_EMPTY;
          res_valid_nxt  = 1'b1;
        end else begin
          rd_en     = 1'b1;
          depth_nxt = depth_m1;
        end
      end
      S_POPW: begin
        if (!pop_idx_r) begin
          t0_nxt      = rd_data;
          pop_idx_nxt = 1'b1;
          if (!two_pops && (op_r == OP_OUT || op_r == OP_OUT_CH)) begin
            res_ov_nxt    = 1'b1;
            res_word_nxt  = rd_data;
            res_valid_nxt = 1'b1;
          end else if (!two_pops && op_r != OP_GET) begin
            res_valid_nxt = 1'b1;
          end
        end else begin
          // Second pop: rd_data is the lower operand, t0_r the top one.
          t1_nxt = rd_data;
          case (op_r)
            OP_SWAP: pv_nxt = t0_r;
            OP_ADD: pv_nxt = rd_data + t0_r;
            OP_SUB: pv_nxt = rd_data - t0_r;
            OP_MUL: alu_req.start = 1'b1;
            OP_POW: begin
              alu_req.start = 1'b1;
              alu_req.op    = ALU_POW;
            end
            default: begin
              if (t0_r == 32'd0) begin
                res_status_nxt = ST_DIV0;
                res_valid_nxt  = 1'b1;
              end else begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
              end
            end
          endcase
        end
      end
      S_GET: begin
        if (bad_index) begin
          res_status_nxt = ST_EMPTY;
          res_valid_nxt  = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = t0_r[AW-1:0];
        end
      end
      S_GETW, S_DUPW: pv_nxt = rd_data;
      S_ALUW: pv_nxt = alu_result;
      S_PUSH: begin
        if (full) begin
          res_status_nxt = ST_FULL;
          res_valid_nxt  = 1'b1;
        end else begin
          wr_en     = 1'b1;
          depth_nxt = depth_r + DW'(1);
          if (op_r != OP_SWAP) begin
            res_valid_nxt = 1'b1;
          end
        end
      end
      S_PUSH2: begin
        wr_en         = 1'b1;
        wr_data       = t1_r;
        depth_nxt     = depth_r + DW'(1);
        res_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      res_valid_r <= res_valid_nxt;
    end
    op_r         <= op_nxt;
    imm_r        <= imm_nxt;
    inw_r        <= inw_nxt;
    t0_r         <= t0_nxt;
    t1_r         <= t1_nxt;
    pv_r         <= pv_nxt;
    pop_idx_r    <= pop_idx_nxt;
    res_status_r <= res_status_nxt;
    res_ov_r     <= res_ov_nxt;
    res_word_r   <= res_word_nxt;
  end

  assign in_item.ready      = (state_r == S_IDLE) && !res_valid_r;
  assign out_item.valid     = res_valid_r;
  assign out_item.status    = res_status_r;
  assign out_item.out_valid = res_ov_r;
  assign out_item.out_word  = res_word_r;

  `SMEU_ASSERT(a_depth_bound, depth_r <= DW'(STACK_DEPTH), "Stack depth overflow")
  `SMEU_ASSERT_NEXT(a_accept_dec, accept, state_r == S_DEC,
                    "Accepted item did not reach decode")
  `SMEU_ASSERT(a_result_src, !$rose(res_valid_r) || $past(state_r) != S_IDLE,
               "Result item raised from idle")

endmodule

### src/smeu_stack.sv
// ----------------------------------------------------------------------------
// Stack memory
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smeu_stack #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/smeu_alu.sv
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// One 32x32 low-half multiplier and one restoring divide step, sequenced
// for multiply, truncating divide and square-and-multiply power.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smeu_alu
  import smeu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  alu_req_t    req,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output alu_rsp_t    rsp,
  output logic [31:0] result
);

  `include "stack_machine_executor_unit_assert.svh"

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  alu_op_t     op_r, op_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] x_r, x_nxt;
  logic [31:0] y_r, y_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] result_r, result_nxt;
  logic [31:0] mul_x, mul_y, prod;
  logic [32:0] rem_sh, diff;
  logic [31:0] q_next;

  assign mul_x  = (op_r == ALU_POW && !phase_r) ? acc_r : x_r;
  assign mul_y  = (op_r == ALU_MUL) ? y_r : x_r;
  assign prod   = mul_x * mul_y;
  assign rem_sh = {acc_r, x_r[31]};
  assign diff   = rem_sh - {1'b0, y_r};
  assign q_next = {x_r[30:0], ~diff[32]};

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    op_nxt     = op_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    acc_nxt    = acc_r;
    result_nxt = result_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      op_nxt    = req.op;
      cnt_nxt   = '0;
      phase_nxt = 1'b0;
      neg_nxt   = a[31] ^ b[31];
      case (req.op)
        ALU_DIV: begin
          x_nxt   = a[31] ? (32'd0 - a) : a;
          y_nxt   = b[31] ? (32'd0 - b) : b;
          acc_nxt = '0;
        end
        ALU_POW: begin
          x_nxt   = a;
          // A negative exponent yields one, so the loop is skipped.
          y_nxt   = b[31] ? 32'd0 : b;
          acc_nxt = 32'd1;
        end
        default: begin
          x_nxt = a;
          y_nxt = b;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        ALU_MUL: begin
          result_nxt = prod;
          busy_nxt   = 1'b0;
          done_nxt   = 1'b1;
        end
        ALU_DIV: begin
          if (!diff[32]) begin
            acc_nxt = diff[31:0];
          end else begin
            acc_nxt = rem_sh[31:0];
          end
          x_nxt   = q_next;
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            result_nxt = neg_r ? (32'd0 - q_next) : q_next;
            busy_nxt   = 1'b0;
            done_nxt   = 1'b1;
          end
        end
        default: begin
          if (y_r == 32'd0) begin
            result_nxt = acc_r;
            busy_nxt   = 1'b0;
            done_nxt   = 1'b1;
          end else if (!phase_r) begin
            if (y_r[0]) begin
              acc_nxt = prod;
            end
            phase_nxt = 1'b1;
          end else begin
            x_nxt     = prod;
            y_nxt     = {1'b0, y_r[31:1]};
            phase_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r     <= op_nxt;
    cnt_r    <= cnt_nxt;
    phase_r  <= phase_nxt;
    neg_r    <= neg_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    acc_r    <= acc_nxt;
    result_r <= result_nxt;
  end

  assign rsp.done = done_r;
  assign result   = result_r;

  `SMEU_ASSERT(a_no_start_busy, !(req.start && busy_r), "ALU started while busy")
  `SMEU_ASSERT(a_done_idle, !(done_r && busy_r), "ALU done while still busy")
  `SMEU_ASSERT_NEXT(a_mul_one, busy_r && !req.start && op_r == ALU_MUL, done_r,
                    "Multiply took more than one cycle")

endmodule
